### rtl/core/sipq_pkg.sv
// Package: types, constants and codes shared by the sorted priority queue files.
package sipq_pkg;

	localparam int DEPTH = 8;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] value;
	} cmd_beat_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] removed_value;
		logic [3:0]         entry_count;
	} rsp_beat_t;

	typedef struct packed {
		logic               rd_en;
		logic [IDX_W-1:0]   rd_addr;
		logic               wr_en;
		logic [IDX_W-1:0]   wr_addr;
		logic signed [31:0] wr_data;
	} mem_req_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_READ,
		SQ_CMP,
		SQ_PUT,
		SQ_FIN
	} seq_state_t;

endpackage

### rtl/core/sipq_store.sv
// Entry store: one write port and one registered read port.
module sipq_store
	import sipq_pkg::*;
(
	input  logic               clk,
	input  mem_req_t           mem_req,
	output logic signed [31:0] rd_data
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem[mem_req.wr_addr] <= mem_req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_req.rd_en) begin
			rd_data <= mem[mem_req.rd_addr];
		end
	end

endmodule

### rtl/core/sipq_seq.sv
// Sequencer: walks the store one entry per step through a single shared comparator.
module sipq_seq
	import sipq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cmd_beat_t          beat,
	output logic               ready,
	output logic               done,
	input  logic               ack,
	output rsp_beat_t          result,
	output mem_req_t           mem_req,
	input  logic signed [31:0] rd_data
);

	seq_state_t         state_q, state_d;
	cmd_t               cmd_q, cmd_d;
	logic signed [31:0] val_q, val_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	status_t            status_q, status_d;
	logic signed [31:0] removed_q, removed_d;
	logic               ge;

	// shared comparator: stored entry against the held value
	assign ge = (rd_data >= val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q     <= cmd_d;
		val_q     <= val_d;
		idx_q     <= idx_d;
		status_q  <= status_d;
		removed_q <= removed_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		val_d     = val_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		status_d  = status_q;
		removed_d = removed_q;
		mem_req   = '0;
		ready     = 1'b0;
		done      = 1'b0;
		unique case (state_q)
			SQ_IDLE: begin
				ready = 1'b1;
				if (start) begin
					cmd_d     = beat.cmd;
					val_d     = beat.value;
					status_d  = ST_OK;
					removed_d = '0;
					idx_d     = '0;
					if (beat.cmd == CMD_INSERT) begin
						if (cnt_q == CNT_W'(DEPTH)) begin
							status_d = ST_FULL;
							state_d  = SQ_FIN;
						end else begin
							idx_d   = IDX_W'(cnt_q);
							state_d = (cnt_q == '0) ? SQ_PUT : SQ_READ;
						end
					end else begin
						if (cnt_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = SQ_FIN;
						end else begin
							state_d = SQ_READ;
						end
					end
				end
			end
			SQ_READ: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = (cmd_q == CMD_INSERT) ? idx_q - IDX_W'(1) : idx_q;
				state_d         = SQ_CMP;
			end
			SQ_CMP: begin
				mem_req.wr_en = 1'b1;
				if (cmd_q == CMD_INSERT) begin
					mem_req.wr_addr = idx_q;
					if (ge) begin
						// move an entry that is not smaller up one slot and keep walking down
						mem_req.wr_data = rd_data;
						idx_d           = idx_q - IDX_W'(1);
						state_d         = (idx_q == IDX_W'(1)) ? SQ_PUT : SQ_READ;
					end else begin
						mem_req.wr_data = val_q;
						cnt_d           = cnt_q + CNT_W'(1);
						state_d         = SQ_FIN;
					end
				end else begin
					// front entry is the result; the rest close up by one slot
					mem_req.wr_en   = (idx_q != '0);
					mem_req.wr_addr = idx_q - IDX_W'(1);
					mem_req.wr_data = rd_data;
					if (idx_q == '0) begin
						removed_d = rd_data;
					end
					idx_d = idx_q + IDX_W'(1);
					if (CNT_W'(idx_q) + CNT_W'(1) == cnt_q) begin
						cnt_d   = cnt_q - CNT_W'(1);
						state_d = SQ_FIN;
					end else begin
						state_d = SQ_READ;
					end
				end
			end
			SQ_PUT: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = idx_q;
				mem_req.wr_data = val_q;
				cnt_d           = cnt_q + CNT_W'(1);
				state_d         = SQ_FIN;
			end
			SQ_FIN: begin
				done = 1'b1;
				if (ack) begin
					state_d = SQ_IDLE;
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	assign result.status        = status_q;
	assign result.removed_value = removed_q;
	assign result.entry_count   = 4'(cnt_q);

endmodule

### rtl/core/sorted_insert_priority_queue.sv
// Top level of the sorted-array ascending priority queue.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+-------------------------------------
//   cmd     | in        | cmd_valid/cmd_stall | cmd_beat_t: cmd, value
//   rsp     | out       | rsp_valid/rsp_stall | rsp_beat_t: status, removed_value,
//           |           |                    |             entry_count
//
// One command is handled at a time. An insert walks down from the top entry, moving each
// stored entry that is not smaller up one slot, and writes the value into the slot left
// free; a remove takes the front entry as the result and closes the rest up by one slot;
// a full insert or an empty remove goes straight to the response. The walk is paced by
// the single store read port and the shared comparator.
// Reset clears the count and the control state; the entry store needs no clearing.
// A stalled response is held in the output register; a new command is taken as soon
// as the sequencer is idle, and the next response waits in the sequencer until the
// register is free.
module sorted_insert_priority_queue
	import sipq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_beat_t cmd_beat,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp_beat
);

	logic               seq_ready;
	logic               seq_done;
	logic               seq_ack;
	logic               start;
	rsp_beat_t          seq_result;
	mem_req_t           mem_req;
	logic signed [31:0] rd_data;
	logic               rsp_valid_q;
	rsp_beat_t          rsp_q;

	// take a command only while the sequencer is idle
	assign cmd_stall = !seq_ready;
	assign start     = cmd_valid && seq_ready;

	// hand the finished beat over when the output register is empty or draining
	assign seq_ack = seq_done && (!rsp_valid_q || !rsp_stall);

	sipq_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.beat    (cmd_beat),
		.ready   (seq_ready),
		.done    (seq_done),
		.ack     (seq_ack),
		.result  (seq_result),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	sipq_store u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	// output register: load on hand-over, drop valid once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (seq_ack) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// hold the payload while stalled
	always_ff @(posedge clk) begin
		if (seq_ack) begin
			rsp_q <= seq_result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_beat  = rsp_q;

endmodule
